/* design/ipv4s_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4s_pkg
// Shared widths and types of the public IPv4 text scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4s_pkg;

  // Width of one reported octet field on the result channel
  localparam int unsigned OCTET_W = 16;

  // Default width of the internal field accumulators
  localparam int unsigned FIELD_WIDTH_DEF = 16;

  // One accepted text byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } byte_req_t;

  // One result request
  typedef struct packed {
    logic               found;
    logic [OCTET_W-1:0] first_octet;
    logic [OCTET_W-1:0] second_octet;
    logic [OCTET_W-1:0] third_octet;
    logic [OCTET_W-1:0] fourth_octet;
  } result_t;

endpackage

`default_nettype wire

/* design/ipv4s_in_if.sv */
// ----------------------------------------------------------------------------
// ipv4s_in_if
// Text byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* design/ipv4s_out_if.sv */
// ----------------------------------------------------------------------------
// ipv4s_out_if
// Result channel: valid/ready handshake with the found flag and four fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4s_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] first_octet;
  logic [15:0] second_octet;
  logic [15:0] third_octet;
  logic [15:0] fourth_octet;

  modport source (
    output valid, output found, output first_octet, output second_octet,
    output third_octet, output fourth_octet, input ready
  );
  modport sink (
    input valid, input found, input first_octet, input second_octet,
    input third_octet, input fourth_octet, output ready
  );
endinterface

`default_nettype wire

/* design/ipv4s_in_stage.sv */
// ----------------------------------------------------------------------------
// ipv4s_in_stage
// Input register: holds one text byte until the scan core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4s_in_stage
  import ipv4s_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ipv4s_in_if.sink       text_i,
  input  wire logic      take_i,
  output logic           valid_o,
  output byte_req_t      req_o
);

  logic      valid_q, valid_d;
  byte_req_t req_q;
  logic      load;

  // refill whenever the slot is empty or being drained this cycle
  assign text_i.ready = !valid_q || take_i;
  assign load         = text_i.valid && text_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.text_byte <= text_i.text_byte;
      req_q.last_byte <= text_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

/* design/ipv4s_scan_core.sv */
// ----------------------------------------------------------------------------
// ipv4s_scan_core
// Token state and field accumulators; judges a token when it closes.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4s_scan_core
  import ipv4s_pkg::*;
#(
  parameter int unsigned FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire byte_req_t  req_i,
  output logic            push_o,
  output result_t         result_o
);

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [2:0] DotsEnd = 3'd4;
  localparam logic [2:0] DotsMin = 3'd3;
  localparam logic [FIELD_WIDTH-1:0] FieldMax = {FIELD_WIDTH{1'b1}};

  logic                   tok_q, tok_d;
  logic [2:0]             dots_q, dots_d;
  logic [FIELD_WIDTH-1:0] fld_q [4];
  logic [FIELD_WIDTH-1:0] fld_d [4];
  logic                   found_q, found_d;

  logic                   is_digit, is_dot;
  logic [3:0]             digit;
  logic [1:0]             sel;
  logic [FIELD_WIDTH-1:0] base;
  logic [FIELD_WIDTH+3:0] wide;
  logic [FIELD_WIDTH-1:0] acc;
  logic                   closing;
  logic                   qualifies;
  logic                   hit;

  function automatic logic [OCTET_W-1:0] to_octet(input logic [FIELD_WIDTH-1:0] v);
    logic [FIELD_WIDTH+OCTET_W-1:0] ext;
    ext = {{OCTET_W{1'b0}}, v};
    return ext[OCTET_W-1:0];
  endfunction

  assign is_digit = (req_i.text_byte >= ChZero) && (req_i.text_byte <= ChNine);
  assign is_dot   = (req_i.text_byte == ChDot);
  assign digit    = 4'(req_i.text_byte - ChZero);

  // a fresh token starts from field zero with cleared accumulators
  assign sel  = tok_q ? dots_q[1:0] : 2'd0;
  assign base = tok_q ? fld_q[sel] : '0;
  assign wide = ({4'b0, base} << 3) + ({4'b0, base} << 1) + (FIELD_WIDTH+4)'(digit);
  assign acc  = (wide > {4'b0, FieldMax}) ? FieldMax : wide[FIELD_WIDTH-1:0];

  always_comb begin
    tok_d    = tok_q;
    dots_d   = dots_q;
    fld_d    = fld_q;
    found_d  = found_q;
    closing  = 1'b0;

    if (!found_q) begin
      if (is_digit) begin
        tok_d = 1'b1;
        if (!tok_q) begin
          dots_d = 3'd0;
          fld_d  = '{default: '0};
        end
        if (dots_d < DotsEnd) begin
          fld_d[sel] = acc;
        end
      end else if (is_dot && tok_q) begin
        if (dots_q < DotsEnd) begin
          dots_d = dots_q + 3'd1;
        end
      end else if (tok_q) begin
        closing = 1'b1;
      end
      // an open token is judged at the end of the text
      if (req_i.last_byte && tok_d) begin
        closing = 1'b1;
      end
      if (closing) begin
        tok_d = 1'b0;
      end
    end
  end

  always_comb begin
    qualifies = (dots_d >= DotsMin) &&
                (fld_d[0] != '0) &&
                (fld_d[0] <= FIELD_WIDTH'(255)) &&
                (fld_d[0] != FIELD_WIDTH'(10)) &&
                !((fld_d[0] == FIELD_WIDTH'(192)) && (fld_d[1] == FIELD_WIDTH'(168))) &&
                !((fld_d[0] == FIELD_WIDTH'(172)) && (fld_d[1] == FIELD_WIDTH'(16)));
  end

  assign hit = closing && qualifies;

  always_comb begin
    push_o   = 1'b0;
    result_o = '0;
    if (advance_i && !found_q) begin
      if (hit) begin
        push_o                = 1'b1;
        result_o.found        = 1'b1;
        result_o.first_octet  = to_octet(fld_d[0]);
        result_o.second_octet = to_octet(fld_d[1]);
        result_o.third_octet  = to_octet(fld_d[2]);
        result_o.fourth_octet = to_octet(fld_d[3]);
      end else if (req_i.last_byte) begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      dots_q  <= 3'd0;
      fld_q   <= '{default: '0};
      found_q <= 1'b0;
    end else if (advance_i) begin
      if (req_i.last_byte) begin
        // end of text: back to the reset state
        tok_q   <= 1'b0;
        dots_q  <= 3'd0;
        fld_q   <= '{default: '0};
        found_q <= 1'b0;
      end else begin
        tok_q   <= tok_d;
        dots_q  <= dots_d;
        fld_q   <= fld_d;
        found_q <= found_d | hit;
      end
    end
  end

endmodule

`default_nettype wire

/* design/ipv4s_out_stage.sv */
// ----------------------------------------------------------------------------
// ipv4s_out_stage
// Result register: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4s_out_stage
  import ipv4s_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire result_t  result_i,
  output logic          free_o,
  ipv4s_out_if.source   result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= result_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.found        = res_q.found;
  assign result_o.first_octet  = res_q.first_octet;
  assign result_o.second_octet = res_q.second_octet;
  assign result_o.third_octet  = res_q.third_octet;
  assign result_o.fourth_octet = res_q.fourth_octet;

endmodule

`default_nettype wire

/* design/public_ipv4_text_scanner.sv */
// ----------------------------------------------------------------------------
// public_ipv4_text_scanner
// Finds the first public dotted-decimal IPv4 address in a byte stream.
// ----------------------------------------------------------------------------
// Feed the text one byte per request on text_i, with last_byte set on the
// final byte. A token is a run of digits and dots that starts with a digit;
// each dot-separated field is read as a decimal number (empty field = 0),
// saturating at 2**FIELD_WIDTH-1, and reported as its low 16 bits. A token
// with at least three dots whose first field is in 1..255, is not 10, and
// is not 192.168 or 172.16 produces one result request with found = 1 and
// the four fields. After that, bytes are swallowed until last_byte. If no
// token qualified, the last byte produces found = 0 with zero fields. Any
// other byte, including high-bit bytes, is a separator. After the last byte
// the scanner is back in its reset state and ready for a new text.
// Rate: one byte per cycle sustained; a byte passes the input register,
// then the scan core judges it and its result is stored in the result
// register. The per-byte path is the field multiply-by-ten plus digit
// add with saturation in the scan core. A held result only stalls intake
// when it is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module public_ipv4_text_scanner
  import ipv4s_pkg::*;
#(
  parameter int unsigned FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ipv4s_in_if.sink     text_i,
  ipv4s_out_if.source  result_o
);

  logic      byte_valid;
  byte_req_t byte_req;
  logic      slot_free;
  logic      advance;
  logic      push;
  result_t   result;

  // hand the held byte to the core only when a result can be stored
  assign advance = byte_valid && slot_free;

  ipv4s_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .take_i  (advance),
    .valid_o (byte_valid),
    .req_o   (byte_req)
  );

  ipv4s_scan_core #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_scan_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (byte_req),
    .push_o    (push),
    .result_o  (result)
  );

  ipv4s_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (result),
    .free_o   (slot_free),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
